[hdl/cau_pkg.sv]
// Shared types and constants for the complex arithmetic unit.
// No dependencies.
`timescale 1ns / 1ps

package cau_pkg;

  localparam int WORD_BITS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;
  localparam int IO_BITS       = 32;

  typedef logic [1:0] op_t;

  localparam op_t OP_ADD = 2'd0;
  localparam op_t OP_SUB = 2'd1;
  localparam op_t OP_MUL = 2'd2;
  localparam op_t OP_DIV = 2'd3;

endpackage

[hdl/cau_div.sv]
// Pipelined restoring divider, two lanes sharing one denominator.
// One quotient bit per stage; carries a side tag and valid bits. Uses cau_pkg nothing.
`timescale 1ns / 1ps

module cau_div #(
  parameter int W     = 32,
  parameter int F     = 16,
  parameter int TAG_W = 8
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               in_valid,
  input  logic [2*W-1:0]     mag_re,
  input  logic [2*W-1:0]     mag_im,
  input  logic [2*W-1:0]     den,
  input  logic [TAG_W-1:0]   tag_in,
  output logic               out_valid,
  output logic [W:0]         quo_re,
  output logic [W:0]         quo_im,
  output logic               big_re,
  output logic               big_im,
  output logic [TAG_W-1:0]   tag_out
);

  localparam int P  = 2 * W;
  localparam int Q  = W + 1;
  localparam int NW = P + F;
  localparam int RW = NW - W - 1;
  localparam int CW = (RW > P) ? RW : P;

  logic [NW-1:0] num     [0:1];
  logic [P-1:0]  rem0    [0:1];
  logic [W:0]    nl0     [0:1];
  logic          big0    [0:1];

  logic [P-1:0]  rem_r   [0:Q][0:1];
  logic [W:0]    quo_r   [0:Q][0:1];
  logic [W:0]    nl_r    [0:Q][0:1];
  logic          big_r   [0:Q][0:1];
  logic [P-1:0]  den_r   [0:Q];
  logic [TAG_W-1:0] tag_r [0:Q];
  logic [Q:0]    vld_r;

  logic [P-1:0]  rem_nxt [1:Q][0:1];
  logic [W:0]    quo_nxt [1:Q][0:1];

  assign num[0] = {mag_re, {F{1'b0}}};
  assign num[1] = {mag_im, {F{1'b0}}};

  always_comb begin
    logic [RW-1:0] hi;
    for (int l = 0; l < 2; l++) begin
      hi      = num[l][NW-1:W+1];
      big0[l] = CW'(hi) >= CW'(den);
      rem0[l] = P'(hi);
      nl0[l]  = num[l][W:0];
    end
  end

  always_comb begin
    logic [P:0] t;
    logic [P:0] diff;
    logic       ge;
    for (int s = 1; s <= Q; s++) begin
      for (int l = 0; l < 2; l++) begin
        t    = {rem_r[s-1][l], nl_r[s-1][l][W]};
        diff = t - {1'b0, den_r[s-1]};
        ge   = t >= {1'b0, den_r[s-1]};
        rem_nxt[s][l] = ge ? diff[P-1:0] : t[P-1:0];
        quo_nxt[s][l] = {quo_r[s-1][l][W-1:0], ge};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      den_r[0] <= den;
      tag_r[0] <= tag_in;
      for (int l = 0; l < 2; l++) begin
        rem_r[0][l] <= rem0[l];
        quo_r[0][l] <= '0;
        nl_r[0][l]  <= nl0[l];
        big_r[0][l] <= big0[l];
      end
      for (int s = 1; s <= Q; s++) begin
        den_r[s] <= den_r[s-1];
        tag_r[s] <= tag_r[s-1];
        for (int l = 0; l < 2; l++) begin
          rem_r[s][l] <= rem_nxt[s][l];
          quo_r[s][l] <= quo_nxt[s][l];
          nl_r[s][l]  <= nl_r[s-1][l] << 1;
          big_r[s][l] <= big_r[s-1][l];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[Q-1:0], in_valid};
    end
  end

  assign out_valid = vld_r[Q];
  assign quo_re    = quo_r[Q][0];
  assign quo_im    = quo_r[Q][1];
  assign big_re    = big_r[Q][0];
  assign big_im    = big_r[Q][1];
  assign tag_out   = tag_r[Q];

endmodule

[hdl/complex_arithmetic_unit_top.sv]
// Complex add, subtract, multiply and divide on signed fixed-point operands.
// Most of the pipeline depth is the divider, which resolves one quotient bit a stage.
// Throughput: one beat per cycle; a stalled output freezes the whole pipeline.
// Reset clears the valid bits only; no other state is kept.
// Depends on cau_pkg and cau_div.
`timescale 1ns / 1ps

module complex_arithmetic_unit_top #(
  parameter int WORD_BITS = cau_pkg::WORD_BITS_DEF,
  parameter int FRAC_BITS = cau_pkg::FRAC_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [1:0]                      in_req_type,
  input  logic signed [cau_pkg::IO_BITS-1:0] in_a_real,
  input  logic signed [cau_pkg::IO_BITS-1:0] in_a_imag,
  input  logic signed [cau_pkg::IO_BITS-1:0] in_b_real,
  input  logic signed [cau_pkg::IO_BITS-1:0] in_b_imag,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic signed [cau_pkg::IO_BITS-1:0] out_result_real,
  output logic signed [cau_pkg::IO_BITS-1:0] out_result_imag,
  output logic                            out_div_by_zero,
  output logic                            out_overflow
);

  localparam int W     = WORD_BITS;
  localparam int F     = FRAC_BITS;
  localparam int P     = 2 * W;
  localparam int S     = P + 1;
  localparam int IOB   = cau_pkg::IO_BITS;
  localparam int TAG_W = 5 + 2 * (W + 1);

  logic en;

  // stage 1: operands
  logic                v1_r;
  cau_pkg::op_t        op1_r;
  logic signed [W-1:0] ar1_r, ai1_r, br1_r, bi1_r;

  // stage 2: products and add/subtract results
  logic                v2_r;
  cau_pkg::op_t        op2_r;
  logic signed [P-1:0] prr2_r, pii2_r, pri2_r, pir2_r, sqr2_r, sqi2_r;
  logic signed [W:0]   asr2_r, asi2_r;
  logic signed [P-1:0] prr_nxt, pii_nxt, pri_nxt, pir_nxt, sqr_nxt, sqi_nxt;
  logic signed [W:0]   asr_nxt, asi_nxt;

  // stage 3: sums
  logic                v3_r;
  cau_pkg::op_t        op3_r;
  logic signed [S-1:0] sre3_r, sim3_r;
  logic [P-1:0]        den3_r;
  logic signed [S-1:0] sre_nxt, sim_nxt;

  // stage 4: sign and magnitude
  logic                v4_r;
  cau_pkg::op_t        op4_r;
  logic                nre4_r, nim4_r, dz4_r;
  logic [P-1:0]        mre4_r, mim4_r, den4_r;
  logic signed [S-1:0] negre_nxt, negim_nxt;

  logic [P-1:0]        shre, shim;
  logic [W:0]          ndre, ndim;
  logic [TAG_W-1:0]    tag_in, tag_out;

  logic                dv_valid, big_re, big_im;
  logic [W:0]          quo_re, quo_im;

  cau_pkg::op_t        op_f;
  logic                dz_f, nre_f, nim_f;
  logic [W:0]          ndre_f, ndim_f, xre, xim;
  logic [W:0]          satre, satim;

  logic                out_valid_r;
  logic [IOB-1:0]      res_re_r, res_im_r;
  logic                dz_r, ovf_r;
  logic [IOB-1:0]      res_re_nxt, res_im_nxt;
  logic                dz_nxt, ovf_nxt;

  function automatic logic [W:0] sat(input logic neg, input logic [W:0] x);
    logic [W:0] lim;
    logic [W:0] ng;
    lim = (W+1)'(1) << (W - 1);
    ng  = -x;
    if (neg) begin
      if (x > lim) begin
        return {1'b1, lim[W-1:0]};
      end
      return {1'b0, ng[W-1:0]};
    end
    if (x > lim - (W+1)'(1)) begin
      return {1'b1, lim[W-1:0] - W'(1)};
    end
    return {1'b0, x[W-1:0]};
  endfunction

  assign en       = !(out_valid_r && out_stall);
  assign in_stall = !en;

  // stage 1
  always_ff @(posedge clk) begin
    if (en) begin
      op1_r <= in_req_type;
      ar1_r <= in_a_real[W-1:0];
      ai1_r <= in_a_imag[W-1:0];
      br1_r <= in_b_real[W-1:0];
      bi1_r <= in_b_imag[W-1:0];
    end
  end

  // stage 2
  assign prr_nxt = P'(ar1_r) * P'(br1_r);
  assign pii_nxt = P'(ai1_r) * P'(bi1_r);
  assign pri_nxt = P'(ar1_r) * P'(bi1_r);
  assign pir_nxt = P'(ai1_r) * P'(br1_r);
  assign sqr_nxt = P'(br1_r) * P'(br1_r);
  assign sqi_nxt = P'(bi1_r) * P'(bi1_r);

  always_comb begin
    if (op1_r == cau_pkg::OP_SUB) begin
      asr_nxt = {ar1_r[W-1], ar1_r} - {br1_r[W-1], br1_r};
      asi_nxt = {ai1_r[W-1], ai1_r} - {bi1_r[W-1], bi1_r};
    end else begin
      asr_nxt = {ar1_r[W-1], ar1_r} + {br1_r[W-1], br1_r};
      asi_nxt = {ai1_r[W-1], ai1_r} + {bi1_r[W-1], bi1_r};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op2_r  <= op1_r;
      prr2_r <= prr_nxt;
      pii2_r <= pii_nxt;
      pri2_r <= pri_nxt;
      pir2_r <= pir_nxt;
      sqr2_r <= sqr_nxt;
      sqi2_r <= sqi_nxt;
      asr2_r <= asr_nxt;
      asi2_r <= asi_nxt;
    end
  end

  // stage 3
  always_comb begin
    unique case (op2_r)
      cau_pkg::OP_MUL: begin
        sre_nxt = {prr2_r[P-1], prr2_r} - {pii2_r[P-1], pii2_r};
        sim_nxt = {pri2_r[P-1], pri2_r} + {pir2_r[P-1], pir2_r};
      end
      cau_pkg::OP_DIV: begin
        sre_nxt = {prr2_r[P-1], prr2_r} + {pii2_r[P-1], pii2_r};
        sim_nxt = {pir2_r[P-1], pir2_r} - {pri2_r[P-1], pri2_r};
      end
      default: begin
        sre_nxt = S'(asr2_r);
        sim_nxt = S'(asi2_r);
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (en) begin
      op3_r  <= op2_r;
      sre3_r <= sre_nxt;
      sim3_r <= sim_nxt;
      den3_r <= sqr2_r + sqi2_r;
    end
  end

  // stage 4
  assign negre_nxt = -sre3_r;
  assign negim_nxt = -sim3_r;

  always_ff @(posedge clk) begin
    if (en) begin
      op4_r  <= op3_r;
      nre4_r <= sre3_r[S-1];
      nim4_r <= sim3_r[S-1];
      mre4_r <= sre3_r[S-1] ? negre_nxt[P-1:0] : sre3_r[P-1:0];
      mim4_r <= sim3_r[S-1] ? negim_nxt[P-1:0] : sim3_r[P-1:0];
      den4_r <= den3_r;
      dz4_r  <= den3_r == '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // clamp the non-divide magnitudes to W+1 bits before they ride along
  assign shre   = (op4_r == cau_pkg::OP_MUL) ? (mre4_r >> F) : mre4_r;
  assign shim   = (op4_r == cau_pkg::OP_MUL) ? (mim4_r >> F) : mim4_r;
  assign ndre   = (|shre[P-1:W+1]) ? '1 : shre[W:0];
  assign ndim   = (|shim[P-1:W+1]) ? '1 : shim[W:0];
  assign tag_in = {op4_r, dz4_r, nre4_r, nim4_r, ndre, ndim};

  cau_div #(
    .W     (W),
    .F     (F),
    .TAG_W (TAG_W)
  ) u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (v4_r),
    .mag_re    (mre4_r),
    .mag_im    (mim4_r),
    .den       (den4_r),
    .tag_in    (tag_in),
    .out_valid (dv_valid),
    .quo_re    (quo_re),
    .quo_im    (quo_im),
    .big_re    (big_re),
    .big_im    (big_im),
    .tag_out   (tag_out)
  );

  // output stage
  assign {op_f, dz_f, nre_f, nim_f, ndre_f, ndim_f} = tag_out;

  assign xre   = (op_f == cau_pkg::OP_DIV) ? (big_re ? '1 : quo_re) : ndre_f;
  assign xim   = (op_f == cau_pkg::OP_DIV) ? (big_im ? '1 : quo_im) : ndim_f;
  assign satre = sat(nre_f, xre);
  assign satim = sat(nim_f, xim);

  always_comb begin
    if (op_f == cau_pkg::OP_DIV && dz_f) begin
      res_re_nxt = '0;
      res_im_nxt = '0;
      dz_nxt     = 1'b1;
      ovf_nxt    = 1'b0;
    end else begin
      res_re_nxt = IOB'($signed(satre[W-1:0]));
      res_im_nxt = IOB'($signed(satim[W-1:0]));
      dz_nxt     = 1'b0;
      ovf_nxt    = satre[W] | satim[W];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_re_r <= res_re_nxt;
      res_im_r <= res_im_nxt;
      dz_r     <= dz_nxt;
      ovf_r    <= ovf_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en) begin
      out_valid_r <= dv_valid;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_real = res_re_r;
  assign out_result_imag = res_im_r;
  assign out_div_by_zero = dz_r;
  assign out_overflow    = ovf_r;

endmodule
